[sv/csl_pkg.sv]
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types, codes and defaults for the C subset lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package csl_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int LENGTH_BITS_DEF = 8;

    localparam int KIND_BITS = 3;
    localparam int CHAR_BITS = 8;

    localparam int REC_QUEUE_DEPTH = 4;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_IDENT   = 3'd0,
        KIND_KEYWORD = 3'd1,
        KIND_INTEGER = 3'd2,
        KIND_PUNCT   = 3'd3,
        KIND_END     = 3'd4,
        KIND_ERROR   = 3'd5
    } kind_t;

    // Records written into the result queue in the same cycle.
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    function automatic logic [CHAR_BITS-1:0] kw_int_char(input logic [1:0] idx);
        logic [CHAR_BITS-1:0] ch;
        case (idx)
            2'd0:    ch = 8'h69;
            2'd1:    ch = 8'h6e;
            2'd2:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_BITS-1:0] kw_return_char(input logic [2:0] idx);
        logic [CHAR_BITS-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h72;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h75;
            3'd4:    ch = 8'h72;
            3'd5:    ch = 8'h6e;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[sv/csl_if.sv]
// ----------------------------------------------------------------------------
// csl_if
// Handshake channels of the lexer: source bytes in, token records out.
// ----------------------------------------------------------------------------
`default_nettype none

interface csl_src_if
    import csl_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] char_code;
    logic                 end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface csl_tok_if
    import csl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [KIND_BITS-1:0]   token_kind;
    logic [OFFSET_BITS-1:0] token_offset;
    logic [LENGTH_BITS-1:0] token_length;
    logic [LINE_BITS-1:0]   token_line;
    logic [COLUMN_BITS-1:0] token_column;
    logic [CHAR_BITS-1:0]   token_char;
    logic                   last_of_run;

    modport source (
        output valid, output token_kind, output token_offset, output token_length,
        output token_line, output token_column, output token_char, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input token_kind, input token_offset, input token_length,
        input token_line, input token_column, input token_char, input last_of_run,
        output ready
    );
endinterface

`default_nettype wire

[sv/csl_scan.sv]
// ----------------------------------------------------------------------------
// csl_scan
// Input register, scanner state and per-byte classification.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_scan
    import csl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    localparam int REC_BITS   = KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS
                                + COLUMN_BITS + CHAR_BITS + 1
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CHAR_BITS-1:0] in_char,
    input  wire logic                 in_eot,
    input  wire logic                 space_ok,
    output push_t                     push,
    output logic [REC_BITS-1:0]       rec0,
    output logic [REC_BITS-1:0]       rec1
);

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] offset;
        logic [LENGTH_BITS-1:0] length;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] column;
        logic [CHAR_BITS-1:0]   ch;
        logic                   last;
    } rec_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT
    } mode_t;

    logic                   s0_valid_reg;
    logic [CHAR_BITS-1:0]   s0_char_reg;
    logic                   s0_eot_reg;

    mode_t                  mode_reg, mode_next;
    logic [1:0]             cand_reg, cand_next;
    logic [OFFSET_BITS-1:0] pend_off_reg, pend_off_next;
    logic [LENGTH_BITS-1:0] pend_len_reg, pend_len_next;
    logic [LINE_BITS-1:0]   pend_line_reg, pend_line_next;
    logic [COLUMN_BITS-1:0] pend_col_reg, pend_col_next;
    logic [OFFSET_BITS-1:0] cur_off_reg, cur_off_next;
    logic [LINE_BITS-1:0]   cur_line_reg, cur_line_next;
    logic [COLUMN_BITS-1:0] cur_col_reg, cur_col_next;

    logic                   fire;
    logic                   is_alpha, is_digit, is_start, is_ident, is_space, is_punct;
    logic                   extend, flush, emit_b, is_kw;
    rec_t                   pend_rec, b_rec, r0, r1;
    logic [OFFSET_BITS-1:0] off_inc;
    logic [LINE_BITS-1:0]   line_inc;
    logic [COLUMN_BITS-1:0] col_inc;
    logic [LENGTH_BITS-1:0] len_inc;

    assign in_ready = !s0_valid_reg || space_ok;
    assign fire     = s0_valid_reg && space_ok;

    always_comb
    begin
        is_alpha = s0_char_reg inside {[8'h61:8'h7a], [8'h41:8'h5a]};
        is_digit = s0_char_reg inside {[8'h30:8'h39]};
        is_start = is_alpha || (s0_char_reg == 8'h5f);
        is_ident = is_start || is_digit;
        is_space = s0_char_reg inside {8'h20, [8'h09:8'h0d]};
        is_punct = s0_char_reg inside {8'h28, 8'h29, 8'h7b, 8'h7d, 8'h3b};

        off_inc  = (cur_off_reg == '1) ? cur_off_reg : cur_off_reg + OFFSET_BITS'(1);
        line_inc = (cur_line_reg == '1) ? cur_line_reg : cur_line_reg + LINE_BITS'(1);
        col_inc  = (cur_col_reg == '1) ? cur_col_reg : cur_col_reg + COLUMN_BITS'(1);
        len_inc  = (pend_len_reg == '1) ? pend_len_reg : pend_len_reg + LENGTH_BITS'(1);

        extend = !s0_eot_reg && (((mode_reg == MODE_IDENT) && is_ident)
                                 || ((mode_reg == MODE_INT) && is_digit));
        flush  = (mode_reg != MODE_IDLE) && !extend;
        emit_b = s0_eot_reg || !(is_space || is_ident);

        is_kw = (cand_reg[0] && (pend_len_reg == LENGTH_BITS'(3)))
                || (cand_reg[1] && (pend_len_reg == LENGTH_BITS'(6)));

        pend_rec.kind   = (mode_reg == MODE_INT) ? KIND_INTEGER
                          : (is_kw ? KIND_KEYWORD : KIND_IDENT);
        pend_rec.offset = pend_off_reg;
        pend_rec.length = pend_len_reg;
        pend_rec.line   = pend_line_reg;
        pend_rec.column = pend_col_reg;
        pend_rec.ch     = '0;
        pend_rec.last   = !emit_b;

        b_rec.kind   = s0_eot_reg ? KIND_END : (is_punct ? KIND_PUNCT : KIND_ERROR);
        b_rec.offset = cur_off_reg;
        b_rec.length = s0_eot_reg ? '0 : LENGTH_BITS'(1);
        b_rec.line   = cur_line_reg;
        b_rec.column = cur_col_reg;
        b_rec.ch     = s0_eot_reg ? '0 : s0_char_reg;
        b_rec.last   = 1'b1;

        r0 = flush ? pend_rec : b_rec;
        r1 = b_rec;

        push.first  = fire && (flush || emit_b);
        push.second = fire && flush && emit_b;

        mode_next      = mode_reg;
        cand_next      = cand_reg;
        pend_off_next  = pend_off_reg;
        pend_len_next  = pend_len_reg;
        pend_line_next = pend_line_reg;
        pend_col_next  = pend_col_reg;
        cur_off_next   = off_inc;
        cur_line_next  = cur_line_reg;
        cur_col_next   = col_inc;

        if (s0_eot_reg)
        begin
            mode_next     = MODE_IDLE;
            cand_next     = '0;
            cur_off_next  = '0;
            cur_line_next = LINE_BITS'(1);
            cur_col_next  = COLUMN_BITS'(1);
        end
        else
        begin
            if (s0_char_reg == 8'h0a)
            begin
                cur_line_next = line_inc;
                cur_col_next  = COLUMN_BITS'(1);
            end
            if (extend)
            begin
                if (mode_reg == MODE_IDENT)
                begin
                    if (!((pend_len_reg < LENGTH_BITS'(3))
                          && (s0_char_reg == kw_int_char(pend_len_reg[1:0]))))
                    begin
                        cand_next[0] = 1'b0;
                    end
                    if (!((pend_len_reg < LENGTH_BITS'(6))
                          && (s0_char_reg == kw_return_char(pend_len_reg[2:0]))))
                    begin
                        cand_next[1] = 1'b0;
                    end
                end
                pend_len_next = len_inc;
            end
            else if (is_ident)
            begin
                mode_next      = is_digit ? MODE_INT : MODE_IDENT;
                cand_next      = is_digit ? 2'b00
                                 : {s0_char_reg == 8'h72, s0_char_reg == 8'h69};
                pend_off_next  = cur_off_reg;
                pend_len_next  = LENGTH_BITS'(1);
                pend_line_next = cur_line_reg;
                pend_col_next  = cur_col_reg;
            end
            else
            begin
                mode_next = MODE_IDLE;
                cand_next = '0;
            end
        end
    end

    assign rec0 = r0;
    assign rec1 = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s0_char_reg   <= '0;
            s0_eot_reg    <= 1'b0;
            mode_reg      <= MODE_IDLE;
            cand_reg      <= '0;
            pend_off_reg  <= '0;
            pend_len_reg  <= '0;
            pend_line_reg <= LINE_BITS'(1);
            pend_col_reg  <= COLUMN_BITS'(1);
            cur_off_reg   <= '0;
            cur_line_reg  <= LINE_BITS'(1);
            cur_col_reg   <= COLUMN_BITS'(1);
        end
        else
        begin
            if (in_ready)
            begin
                s0_valid_reg <= in_valid;
                s0_char_reg  <= in_char;
                s0_eot_reg   <= in_eot;
            end
            if (fire)
            begin
                mode_reg      <= mode_next;
                cand_reg      <= cand_next;
                pend_off_reg  <= pend_off_next;
                pend_len_reg  <= pend_len_next;
                pend_line_reg <= pend_line_next;
                pend_col_reg  <= pend_col_next;
                cur_off_reg   <= cur_off_next;
                cur_line_reg  <= cur_line_next;
                cur_col_reg   <= cur_col_next;
            end
        end
    end

endmodule

`default_nettype wire

[sv/csl_rec_queue.sv]
// ----------------------------------------------------------------------------
// csl_rec_queue
// Small result queue that takes up to two records a cycle and gives one while the reader is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_rec_queue
    import csl_pkg::*;
#(
    parameter int WIDTH = 8
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire push_t            push,
    input  wire logic [WIDTH-1:0] wr0,
    input  wire logic [WIDTH-1:0] wr1,
    output logic                  space_ok,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int PTR_BITS = $clog2(REC_QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(REC_QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [REC_QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                pop;
    logic [CNT_BITS-1:0] n_push;

    assign pop      = rd_valid && rd_ready;
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign space_ok = count_reg <= CNT_BITS'(REC_QUEUE_DEPTH - 2);
    assign n_push   = CNT_BITS'(push.first) + CNT_BITS'(push.second);

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem_reg[wr_ptr_reg] <= wr0;
        end
        if (push.second)
        begin
            mem_reg[wr_ptr_reg + PTR_BITS'(1)] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(n_push);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            count_reg <= count_reg + n_push - CNT_BITS'(pop);
        end
    end

endmodule

`default_nettype wire

[sv/c_subset_lexer.sv]
// ----------------------------------------------------------------------------
// c_subset_lexer
// Streaming lexer for a small C subset: source bytes in, token records out.
// ----------------------------------------------------------------------------
//   Channel  Side    Carries
//   src      sink    char_code, end_of_text: one source byte or end of text
//   tok      source  token_kind .. last_of_run: one token record
//
// A byte is registered on acceptance and classified from that register;
// once the queue has room, its records are written into a four-entry result queue.
// One byte is taken every cycle while the queue has room; a byte that yields two
// records sends them out one after the other, so the sustained rate is one item per record.
// The input stalls only when the queue holds more than two records.
// Reset is asynchronous and returns the position counters to offset 0,
// line 1, column 1.
`default_nettype none

module c_subset_lexer
    import csl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    csl_src_if.sink    src,
    csl_tok_if.source  tok
);

    localparam int REC_BITS = KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS
                              + COLUMN_BITS + CHAR_BITS + 1;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] offset;
        logic [LENGTH_BITS-1:0] length;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] column;
        logic [CHAR_BITS-1:0]   ch;
        logic                   last;
    } rec_t;

    push_t               push;
    logic                space_ok;
    logic [REC_BITS-1:0] rec0, rec1, rd_data;
    rec_t                out_rec;

    csl_scan #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (src.valid),
        .in_ready (src.ready),
        .in_char  (src.char_code),
        .in_eot   (src.end_of_text),
        .space_ok (space_ok),
        .push     (push),
        .rec0     (rec0),
        .rec1     (rec1)
    );

    csl_rec_queue #(
        .WIDTH (REC_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr0      (rec0),
        .wr1      (rec1),
        .space_ok (space_ok),
        .rd_valid (tok.valid),
        .rd_ready (tok.ready),
        .rd_data  (rd_data)
    );

    assign out_rec          = rec_t'(rd_data);
    assign tok.token_kind   = out_rec.kind;
    assign tok.token_offset = out_rec.offset;
    assign tok.token_length = out_rec.length;
    assign tok.token_line   = out_rec.line;
    assign tok.token_column = out_rec.column;
    assign tok.token_char   = out_rec.ch;
    assign tok.last_of_run  = out_rec.last;

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tok.valid && (tok.token_kind == KIND_END)) |-> tok.last_of_run)
        else $error("end record not marked as last of its run");

    a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
        (tok.valid && ((tok.token_kind == KIND_PUNCT) || (tok.token_kind == KIND_ERROR)))
        |-> (tok.token_length == LENGTH_BITS'(1)))
        else $error("punctuation or error record with length other than one");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("second record written without the first");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (tok.valid && tok.ready && !tok.last_of_run) |=> tok.valid)
        else $error("record pair split across an empty queue");

endmodule

`default_nettype wire

[bench/tb_c_subset_lexer.sv]
// ----------------------------------------------------------------------------
// tb_c_subset_lexer
// Self-checking bench for the C subset lexer. Source bytes are offered on the
// input channel with random gaps while the token channel stalls at random.
// Every accepted byte is run through a behavioural lexer in the bench, and
// each token record that leaves the block is compared field by field with
// the oldest record still due. Directed text, a saturating token length,
// a long output hold-off and random C-like text are covered.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_c_subset_lexer;

    import csl_pkg::*;

    localparam int OFF_W  = OFFSET_BITS_DEF;
    localparam int LINE_W = LINE_BITS_DEF;
    localparam int COL_W  = COLUMN_BITS_DEF;
    localparam int LEN_W  = LENGTH_BITS_DEF;

    localparam int  LONG_HOLD   = 300;
    localparam int  DRAIN_LIMIT = 20000;
    localparam int  TAIL_CYCLES = 8;
    localparam int  TIMEOUT_NS  = 30_000_000;

    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_UNDER  = "_";

    localparam logic [7:0] KW_INT    [0:2] = '{"i", "n", "t"};
    localparam logic [7:0] KW_RETURN [0:5] = '{"r", "e", "t", "u", "r", "n"};

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_NUMBER
    } scan_t;

    typedef struct packed {
        kind_t              kind;
        logic [OFF_W-1:0]   offset;
        logic [LEN_W-1:0]   length;
        logic [LINE_W-1:0]  line;
        logic [COL_W-1:0]   column;
        logic [CHAR_BITS-1:0] chr;
        logic               last;
    } token_rec_t;

    logic clk = 1'b0;
    logic rst_n;

    csl_src_if src_ch ();
    csl_tok_if tok_ch ();

    c_subset_lexer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_ch),
        .tok   (tok_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Lexer state of the bench's own model.
    scan_t              scan_state = SCAN_IDLE;
    logic [1:0]         kw_alive   = 2'b00;
    logic [OFF_W-1:0]   word_off   = '0;
    logic [LEN_W-1:0]   word_len   = '0;
    logic [LINE_W-1:0]  word_line  = LINE_W'(1);
    logic [COL_W-1:0]   word_col   = COL_W'(1);
    logic [OFF_W-1:0]   pos_off    = '0;
    logic [LINE_W-1:0]  pos_line   = LINE_W'(1);
    logic [COL_W-1:0]   pos_col    = COL_W'(1);

    token_rec_t tokens_due [$];

    int  items_sent     = 0;
    int  items_seen     = 0;
    int  bytes_sent     = 0;
    int  ends_sent      = 0;
    int  tokens_checked = 0;
    int  error_count    = 0;
    bit  src_gaps       = 1'b1;
    bit  sink_stalls    = 1'b1;
    bit  long_hold_req  = 1'b0;
    int  hold_count;

    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string near_words [0:9] = '{"int", "return", "in", "inta", "retur", "returnx",
                                "i", "r", "int_", "Int"};

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_start(input logic [7:0] c);
        return is_alpha(c) || c == CH_UNDER;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_punct(input logic [7:0] c);
        return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE
            || c == CH_SEMI;
    endfunction

    function automatic void push_token(input kind_t k, input logic [OFF_W-1:0] off,
                                       input logic [LEN_W-1:0] len,
                                       input logic [LINE_W-1:0] line,
                                       input logic [COL_W-1:0] col,
                                       input logic [7:0] ch);
        token_rec_t rec;
        rec.kind   = k;
        rec.offset = off;
        rec.length = len;
        rec.line   = line;
        rec.column = col;
        rec.chr    = ch;
        rec.last   = 1'b0;
        tokens_due.push_back(rec);
    endfunction

    function automatic void flush_word();
        kind_t k;
        if (scan_state == SCAN_IDLE)
            return;
        if (scan_state == SCAN_NUMBER)
            k = KIND_INTEGER;
        else if ((kw_alive[0] && word_len == LEN_W'(3))
                 || (kw_alive[1] && word_len == LEN_W'(6)))
            k = KIND_KEYWORD;
        else
            k = KIND_IDENT;
        push_token(k, word_off, word_len, word_line, word_col, 8'h00);
        scan_state = SCAN_IDLE;
        kw_alive   = 2'b00;
    endfunction

    function automatic void advance_position(input logic [7:0] c);
        if (pos_off != '1)
            pos_off = pos_off + OFF_W'(1);
        if (c == CH_NL)
        begin
            if (pos_line != '1)
                pos_line = pos_line + LINE_W'(1);
            pos_col = COL_W'(1);
        end
        else if (pos_col != '1)
        begin
            pos_col = pos_col + COL_W'(1);
        end
    endfunction

    function automatic void lex_predict(input logic [7:0] c, input logic eot);
        int         first;
        token_rec_t tail;
        first = tokens_due.size();
        if (eot)
        begin
            flush_word();
            push_token(KIND_END, pos_off, '0, pos_line, pos_col, 8'h00);
            pos_off  = '0;
            pos_line = LINE_W'(1);
            pos_col  = COL_W'(1);
        end
        else if ((scan_state == SCAN_WORD && (is_word_start(c) || is_digit(c)))
                 || (scan_state == SCAN_NUMBER && is_digit(c)))
        begin
            if (scan_state == SCAN_WORD)
            begin
                if (!(word_len < LEN_W'(3) && c == KW_INT[word_len]))
                    kw_alive[0] = 1'b0;
                if (!(word_len < LEN_W'(6) && c == KW_RETURN[word_len]))
                    kw_alive[1] = 1'b0;
            end
            if (word_len != '1)
                word_len = word_len + LEN_W'(1);
            advance_position(c);
        end
        else
        begin
            flush_word();
            if (is_space(c))
            begin
            end
            else if (is_word_start(c) || is_digit(c))
            begin
                scan_state = is_digit(c) ? SCAN_NUMBER : SCAN_WORD;
                kw_alive   = is_digit(c) ? 2'b00 : {c == KW_RETURN[0], c == KW_INT[0]};
                word_off   = pos_off;
                word_len   = LEN_W'(1);
                word_line  = pos_line;
                word_col   = pos_col;
            end
            else
            begin
                push_token(is_punct(c) ? KIND_PUNCT : KIND_ERROR, pos_off, LEN_W'(1),
                           pos_line, pos_col, c);
            end
            advance_position(c);
        end
        if (tokens_due.size() > first)
        begin
            tail = tokens_due.pop_back();
            tail.last = 1'b1;
            tokens_due.push_back(tail);
        end
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 100)
            $display("tb_c_subset_lexer: mismatch: %s", msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("record %0d: %s is %0d, expected %0d",
                                   tokens_checked, name, got, want));
    endtask

    task automatic check_token();
        token_rec_t want;
        if (tokens_due.size() == 0)
        begin
            report_error($sformatf("record of kind %0d at offset %0d with nothing due",
                                   tok_ch.token_kind, tok_ch.token_offset));
            return;
        end
        want = tokens_due.pop_front();
        tokens_checked++;
        compare_field("kind",   32'(tok_ch.token_kind),   32'(want.kind));
        compare_field("offset", 32'(tok_ch.token_offset), 32'(want.offset));
        compare_field("length", 32'(tok_ch.token_length), 32'(want.length));
        compare_field("line",   32'(tok_ch.token_line),   32'(want.line));
        compare_field("column", 32'(tok_ch.token_column), 32'(want.column));
        compare_field("char",   32'(tok_ch.token_char),   32'(want.chr));
        compare_field("last",   32'(tok_ch.last_of_run),  32'(want.last));
    endtask

    // Bytes are modelled before records are checked, so the order in which the
    // processes wake up cannot matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_ch.valid && src_ch.ready)
            begin
                lex_predict(src_ch.char_code, src_ch.end_of_text);
                items_seen++;
            end
            if (tok_ch.valid && tok_ch.ready)
                check_token();
        end
    end

    initial
    begin : token_sink
        tok_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                tok_ch.ready <= 1'b0;
                for (hold_count = 0; hold_count < LONG_HOLD; hold_count++)
                    @(posedge clk);
                long_hold_req = 1'b0;
                tok_ch.ready <= 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                tok_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                tok_ch.ready <= 1'b1;
            end
            else
            begin
                tok_ch.ready <= 1'b1;
            end
        end
    end

    task automatic push_item(input logic [7:0] c, input logic eot);
        src_ch.valid       <= 1'b1;
        src_ch.char_code   <= c;
        src_ch.end_of_text <= eot;
        do @(posedge clk); while (!src_ch.ready);
        items_sent++;
        if (eot)
            ends_sent++;
        else
            bytes_sent++;
    endtask

    task automatic source_gap();
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            src_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] c);
        source_gap();
        push_item(c, 1'b0);
    endtask

    task automatic send_end();
        source_gap();
        push_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_idle();
        int n;
        src_ch.valid <= 1'b0;
        n = 0;
        while ((items_seen != items_sent || tokens_due.size() != 0) && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        send_text("int return 12ab\n(){};x");
        send_byte(8'h00);
        send_byte(8'hff);
        send_end();
        wait_idle();
    endtask

    task automatic test_long_tokens();
        send_byte("w");
        for (int i = 1; i < 260; i++)
            send_byte(word_chars[$urandom_range(0, 62)]);
        send_byte(CH_SPACE);
        for (int i = 0; i < 20; i++)
            send_byte(8'("0" + $urandom_range(0, 9)));
        send_end();
        wait_idle();
    endtask

    task automatic send_fragment();
        int    pick;
        int    len;
        string w;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            w = near_words[$urandom_range(0, 9)];
            send_text(w);
        end
        else if (pick < 40)
        begin
            len = $urandom_range(1, 12);
            send_byte(word_chars[$urandom_range(0, 52)]);
            for (int i = 1; i < len; i++)
                send_byte(word_chars[$urandom_range(0, 62)]);
        end
        else if (pick < 52)
        begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
                send_byte(8'("0" + $urandom_range(0, 9)));
        end
        else if (pick < 70)
        begin
            case ($urandom_range(0, 4))
                0:       send_byte(CH_LPAREN);
                1:       send_byte(CH_RPAREN);
                2:       send_byte(CH_LBRACE);
                3:       send_byte(CH_RBRACE);
                default: send_byte(CH_SEMI);
            endcase
        end
        else if (pick < 85)
        begin
            if ($urandom_range(0, 1) == 0)
                send_byte(CH_SPACE);
            else
                send_byte(8'($urandom_range(9, 13)));
        end
        else if (pick < 97)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            send_end();
        end
    endtask

    task automatic test_random_text(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items)
            send_fragment();
        send_end();
        wait_idle();
    endtask

    task automatic test_backpressure();
        bit saved_gaps;
        saved_gaps    = src_gaps;
        src_gaps      = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 20; i++)
            send_text("a(");
        send_end();
        src_gaps = saved_gaps;
        wait_idle();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        src_ch.valid       = 1'b0;
        src_ch.char_code   = '0;
        src_ch.end_of_text = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_long_tokens();
        test_random_text(190);
        test_backpressure();

        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        test_random_text(100);

        if (tokens_due.size() != 0)
            report_error($sformatf("%0d records never arrived", tokens_due.size()));
        $display("tb_c_subset_lexer: %0d bytes and %0d end marks lexed, %0d records checked",
                 bytes_sent, ends_sent, tokens_checked);
        $display("tb_c_subset_lexer: keywords, a saturating length and a long hold-off");
        if (error_count == 0)
            $display("tb_c_subset_lexer: PASS");
        else
            $display("tb_c_subset_lexer: FAIL");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_c_subset_lexer: timed out");
        $display("tb_c_subset_lexer: FAIL");
        $finish;
    end

endmodule

[files.f]
sv/csl_pkg.sv
sv/csl_if.sv
sv/csl_scan.sv
sv/csl_rec_queue.sv
sv/c_subset_lexer.sv
bench/tb_c_subset_lexer.sv
